// ===== hw/rtl/epoch_ms_to_local_calendar_assert.svh =====
// Assertion macros used by the checker of the epoch-to-calendar block.
`ifndef EPOCH_MS_TO_LOCAL_CALENDAR_ASSERT_SVH
`define EPOCH_MS_TO_LOCAL_CALENDAR_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define EM2C_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("em2c assertion failed");

// Next-cycle implication, switched off while reset is high.
`define EM2C_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("em2c assertion failed");

// Next-cycle implication that is checked through reset as well.
`define EM2C_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("em2c assertion failed");

`endif

// ===== hw/rtl/em2c_pkg.sv =====
// Shared constants, types and tables of the epoch-to-calendar pipeline.
package em2c_pkg;

  // Pipeline layout: one add stage, four day-division stages, seven branch stages.
  localparam int NUM_STAGES = 12;
  localparam int DAY_FIRST  = 1;
  localparam int DAY_STAGES = 4;
  localparam int BR_FIRST   = 5;

  typedef struct packed {
    logic [NUM_STAGES-1:0] ld;
  } em2c_pipe_t;

  // Configuration.
  localparam logic       REG_TZ        = 1'b0;
  localparam logic [6:0] TZ_RESET      = 7'd22;
  localparam logic signed [26:0] MS_PER_QUARTER = 27'sd900000;
  localparam logic signed [26:0] OFFSET_RESET   = 27'sd19800000;

  // Milliseconds per day is 84375 shifted left by ten.
  localparam int          DAY_SHIFT            = 10;
  localparam logic [17:0] DAY_DIV              = 18'd84375;
  localparam int          DAY_STEPS            = 22;
  localparam int          DAY_STEPS_PER_STAGE  = 6;

  // Civil date constants.
  localparam logic [21:0] DAYS_SHIFT   = 22'd719468;
  localparam logic [18:0] ERA_DAYS     = 19'd146097;
  localparam logic [11:0] QUAD_DAYS    = 12'd1460;
  localparam logic [16:0] CENT_DAYS    = 17'd36524;
  localparam logic [17:0] ERA_LAST_DAY = 18'd146096;
  localparam logic [9:0]  YEAR_DAYS    = 10'd365;
  localparam int          YOE_STEPS_A  = 4;
  localparam int          YOE_STEPS_B  = 5;
  localparam logic [8:0]  MP_DIV       = 9'd153;

  // Time of day: seconds are milliseconds shifted right by three, then over 125.
  localparam logic [7:0]  SEC_DIV             = 8'd125;
  localparam int          TOD_STEPS           = 17;
  localparam int          TOD_STEPS_PER_STAGE = 6;
  localparam int          TOD_STAGES          = 3;
  localparam logic [12:0] SECS_PER_HOUR       = 13'd3600;
  localparam logic [6:0]  SECS_PER_MIN        = 7'd60;

  // First day of each March-based month within the year.
  function automatic logic [8:0] month_base(input logic [3:0] mp);
    logic [8:0] base;
    case (mp)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd61;
      4'd3:    base = 9'd92;
      4'd4:    base = 9'd122;
      4'd5:    base = 9'd153;
      4'd6:    base = 9'd184;
      4'd7:    base = 9'd214;
      4'd8:    base = 9'd245;
      4'd9:    base = 9'd275;
      4'd10:   base = 9'd306;
      4'd11:   base = 9'd337;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

// ===== hw/rtl/epoch_ms_to_local_calendar.sv =====
// Top level: UTC millisecond timestamps to local Gregorian date and time of day.
// Each transaction on the input stream carries a 48-bit count of UTC milliseconds since
// 1970; the block adds the time-zone offset held in register 0 (signed quarter hours,
// reset +22) and returns one result transaction with year, month, day, hour, minute and
// second, milliseconds dropped. A local time before 1970 sets the error flag in tuser and
// zeroes every other field. The pipeline takes one transaction per clock while the output is
// not stalled and has twelve register stages; that depth comes from the restoring division
// stages that split milliseconds into days and then days into eras, years and months.
// Write the offset only while no transaction is in flight.
module epoch_ms_to_local_calendar import em2c_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [47:0] UTC milliseconds
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [13:0] year, [17:14] month, [22:18] day,
                                 // [27:23] hour, [33:28] minute, [39:34] second
  output logic [0:0]  m_tuser    // [0] error
);

  logic [6:0]         tz_quarter_hours;
  logic signed [26:0] offset_ms;
  em2c_pipe_t         ctrl;

  logic        split_err;
  logic [21:0] days;
  logic [26:0] msod;
  logic        res_err;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  // The offset in milliseconds is formed when the register is written.
  always_ff @(posedge clk) begin
    if (rst) begin
      tz_quarter_hours <= TZ_RESET;
      offset_ms        <= OFFSET_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TZ) begin
      tz_quarter_hours <= pwdata[6:0];
      offset_ms        <= 27'(signed'(pwdata[6:0])) * MS_PER_QUARTER;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TZ) ? {25'd0, tz_quarter_hours} : 32'd0;

  em2c_pipe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .m_tready (m_tready),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .ctrl     (ctrl)
  );

  em2c_day_split u_split (
    .clk       (clk),
    .ctrl      (ctrl),
    .utc_ms    (s_tdata),
    .offset_ms (offset_ms),
    .err       (split_err),
    .days      (days),
    .msod      (msod)
  );

  em2c_civil_date u_date (
    .clk    (clk),
    .ctrl   (ctrl),
    .err_in (split_err),
    .days   (days),
    .err    (res_err),
    .year   (year),
    .month  (month),
    .day    (day)
  );

  em2c_time_of_day u_tod (
    .clk    (clk),
    .ctrl   (ctrl),
    .msod   (msod),
    .hour   (hour),
    .minute (minute),
    .second (second)
  );

  assign m_tdata = res_err ? 40'd0 : {second, minute, hour, day, month, year};
  assign m_tuser = res_err;

endmodule

// ===== hw/rtl/em2c_pipe_ctrl.sv =====
// Valid bits and per-stage load enables of the conversion pipeline.
module em2c_pipe_ctrl import em2c_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       m_tready,
  output logic       s_tready,
  output logic       m_tvalid,
  output em2c_pipe_t ctrl
);

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] vld_next;
  logic [NUM_STAGES-1:0] ld;

  // A stage may load when it is empty or when its contents move on, so bubbles collapse.
  always_comb begin
    ld[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  always_comb begin
    vld_next = vld;
    if (ld[0]) begin
      vld_next[0] = s_tvalid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (ld[k]) begin
        vld_next[k] = vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign ctrl.ld  = ld;
  assign s_tready = ld[0];
  assign m_tvalid = vld[NUM_STAGES-1];

endmodule

// ===== hw/rtl/em2c_day_split.sv =====
// Offset add and restoring division of local milliseconds into whole days and time of day.
module em2c_day_split import em2c_pkg::*; (
  input  logic               clk,
  input  em2c_pipe_t         ctrl,
  input  logic [47:0]        utc_ms,
  input  logic signed [26:0] offset_ms,
  output logic               err,
  output logic [21:0]        days,
  output logic [26:0]        msod
);

  logic signed [49:0] loc_ms;

  // Index 0 holds the add stage, indexes 1 to 4 the division stages.
  logic        err_q [DAY_STAGES+1];
  logic [9:0]  low_q [DAY_STAGES+1];
  logic [16:0] rem_q [DAY_STAGES+1];
  logic [21:0] pq_q  [DAY_STAGES+1];

  assign loc_ms = signed'({2'b00, utc_ms}) + 50'(offset_ms);

  // The quotient is below 2^22, so the top 17 bits already sit below the divisor.
  always_ff @(posedge clk) begin
    if (ctrl.ld[0]) begin
      err_q[0] <= loc_ms[49];
      low_q[0] <= loc_ms[DAY_SHIFT-1:0];
      rem_q[0] <= loc_ms[48:32];
      pq_q[0]  <= loc_ms[31:DAY_SHIFT];
    end
  end

  // The pq register shifts dividend bits out at the top and quotient bits in at the bottom.
  for (genvar s = 0; s < DAY_STAGES; s++) begin : g_div
    logic [16:0] rem_n;
    logic [21:0] pq_n;
    logic [17:0] trial;

    always_comb begin
      rem_n = rem_q[s];
      pq_n  = pq_q[s];
      trial = '0;
      for (int j = 0; j < DAY_STEPS_PER_STAGE; j++) begin
        if (s * DAY_STEPS_PER_STAGE + j < DAY_STEPS) begin
          trial = {rem_n, pq_n[21]};
          pq_n  = {pq_n[20:0], trial >= DAY_DIV};
          if (pq_n[0]) begin
            rem_n = 17'(trial - DAY_DIV);
          end else begin
            rem_n = trial[16:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.ld[DAY_FIRST+s]) begin
        err_q[s+1] <= err_q[s];
        low_q[s+1] <= low_q[s];
        rem_q[s+1] <= rem_n;
        pq_q[s+1]  <= pq_n;
      end
    end
  end

  assign err  = err_q[DAY_STAGES];
  assign days = pq_q[DAY_STAGES];
  assign msod = {rem_q[DAY_STAGES], low_q[DAY_STAGES]};

endmodule

// ===== hw/rtl/em2c_civil_date.sv =====
// Days since 1970 to proleptic Gregorian year, month and day over seven stages.
module em2c_civil_date import em2c_pkg::*; (
  input  logic        clk,
  input  em2c_pipe_t  ctrl,
  input  logic        err_in,
  input  logic [21:0] days,
  output logic        err,
  output logic [13:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day
);

  // Stage 1: shift to the March-based epoch, split into eras.
  logic [21:0] dd;
  logic [17:0] er_rem;
  logic [4:0]  er_pq;
  logic [18:0] er_trial;
  logic        c1_err;
  logic [4:0]  c1_era;
  logic [17:0] c1_doe;

  always_comb begin
    dd       = days + DAYS_SHIFT;
    er_rem   = {1'b0, dd[21:5]};
    er_pq    = dd[4:0];
    er_trial = '0;
    for (int j = 0; j < 5; j++) begin
      er_trial = {er_rem, er_pq[4]};
      er_pq    = {er_pq[3:0], er_trial >= ERA_DAYS};
      if (er_pq[0]) begin
        er_rem = 18'(er_trial - ERA_DAYS);
      end else begin
        er_rem = er_trial[17:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[BR_FIRST]) begin
      c1_err <= err_in;
      c1_era <= er_pq;
      c1_doe <= er_rem;
    end
  end

  // Stage 2: leap corrections, day of era over 1460, over 36524, and the era's last day.
  logic [10:0] qa_rem;
  logic [6:0]  qa_pq;
  logic [11:0] qa_trial;
  logic [15:0] qb_rem;
  logic [2:0]  qb_pq;
  logic [16:0] qb_trial;
  logic        c2_err;
  logic [4:0]  c2_era;
  logic [17:0] c2_doe;
  logic [6:0]  c2_a;
  logic [2:0]  c2_b;
  logic        c2_c;

  always_comb begin
    qa_rem   = c1_doe[17:7];
    qa_pq    = c1_doe[6:0];
    qa_trial = '0;
    for (int j = 0; j < 7; j++) begin
      qa_trial = {qa_rem, qa_pq[6]};
      qa_pq    = {qa_pq[5:0], qa_trial >= QUAD_DAYS};
      if (qa_pq[0]) begin
        qa_rem = 11'(qa_trial - QUAD_DAYS);
      end else begin
        qa_rem = qa_trial[10:0];
      end
    end
    qb_rem   = {1'b0, c1_doe[17:3]};
    qb_pq    = c1_doe[2:0];
    qb_trial = '0;
    for (int j = 0; j < 3; j++) begin
      qb_trial = {qb_rem, qb_pq[2]};
      qb_pq    = {qb_pq[1:0], qb_trial >= CENT_DAYS};
      if (qb_pq[0]) begin
        qb_rem = 16'(qb_trial - CENT_DAYS);
      end else begin
        qb_rem = qb_trial[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[BR_FIRST+1]) begin
      c2_err <= c1_err;
      c2_era <= c1_era;
      c2_doe <= c1_doe;
      c2_a   <= qa_pq;
      c2_b   <= qb_pq;
      c2_c   <= (c1_doe == ERA_LAST_DAY);
    end
  end

  // Stages 3 and 4: year of era, a restoring division by 365 split over two stages.
  logic [17:0] num;
  logic [8:0]  ya_rem;
  logic [8:0]  ya_pq;
  logic [9:0]  ya_trial;
  logic        c3_err;
  logic [4:0]  c3_era;
  logic [17:0] c3_doe;
  logic [8:0]  c3_rem;
  logic [8:0]  c3_pq;

  always_comb begin
    num      = c2_doe - 18'(c2_a) + 18'(c2_b) - 18'(c2_c);
    ya_rem   = num[17:9];
    ya_pq    = num[8:0];
    ya_trial = '0;
    for (int j = 0; j < YOE_STEPS_A; j++) begin
      ya_trial = {ya_rem, ya_pq[8]};
      ya_pq    = {ya_pq[7:0], ya_trial >= YEAR_DAYS};
      if (ya_pq[0]) begin
        ya_rem = 9'(ya_trial - YEAR_DAYS);
      end else begin
        ya_rem = ya_trial[8:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[BR_FIRST+2]) begin
      c3_err <= c2_err;
      c3_era <= c2_era;
      c3_doe <= c2_doe;
      c3_rem <= ya_rem;
      c3_pq  <= ya_pq;
    end
  end

  logic [8:0] yb_rem;
  logic [8:0] yb_pq;
  logic [9:0] yb_trial;
  logic       c4_err;
  logic [4:0] c4_era;
  logic [17:0] c4_doe;
  logic [8:0] c4_yoe;

  always_comb begin
    yb_rem   = c3_rem;
    yb_pq    = c3_pq;
    yb_trial = '0;
    for (int j = 0; j < YOE_STEPS_B; j++) begin
      yb_trial = {yb_rem, yb_pq[8]};
      yb_pq    = {yb_pq[7:0], yb_trial >= YEAR_DAYS};
      if (yb_pq[0]) begin
        yb_rem = 9'(yb_trial - YEAR_DAYS);
      end else begin
        yb_rem = yb_trial[8:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[BR_FIRST+3]) begin
      c4_err <= c3_err;
      c4_era <= c3_era;
      c4_doe <= c3_doe;
      c4_yoe <= yb_pq;
    end
  end

  // Stage 5: day of the March-based year.
  logic [1:0]  cent;
  logic [17:0] doy_full;
  logic        c5_err;
  logic [4:0]  c5_era;
  logic [8:0]  c5_yoe;
  logic [8:0]  c5_doy;

  always_comb begin
    if (c4_yoe >= 9'd300) begin
      cent = 2'd3;
    end else if (c4_yoe >= 9'd200) begin
      cent = 2'd2;
    end else if (c4_yoe >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
    doy_full = c4_doe - (18'(c4_yoe) * 18'(YEAR_DAYS) + 18'(c4_yoe[8:2]) - 18'(cent));
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[BR_FIRST+4]) begin
      c5_err <= c4_err;
      c5_era <= c4_era;
      c5_yoe <= c4_yoe;
      c5_doy <= doy_full[8:0];
    end
  end

  // Stage 6: March-based month index, (5 * doy + 2) over 153.
  logic [10:0] mt;
  logic [7:0]  mp_rem;
  logic [3:0]  mp_pq;
  logic [8:0]  mp_trial;
  logic        c6_err;
  logic [4:0]  c6_era;
  logic [8:0]  c6_yoe;
  logic [8:0]  c6_doy;
  logic [3:0]  c6_mp;

  always_comb begin
    mt       = 11'(c5_doy) * 11'd5 + 11'd2;
    mp_rem   = {1'b0, mt[10:4]};
    mp_pq    = mt[3:0];
    mp_trial = '0;
    for (int j = 0; j < 4; j++) begin
      mp_trial = {mp_rem, mp_pq[3]};
      mp_pq    = {mp_pq[2:0], mp_trial >= MP_DIV};
      if (mp_pq[0]) begin
        mp_rem = 8'(mp_trial - MP_DIV);
      end else begin
        mp_rem = mp_trial[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[BR_FIRST+5]) begin
      c6_err <= c5_err;
      c6_era <= c5_era;
      c6_yoe <= c5_yoe;
      c6_doy <= c5_doy;
      c6_mp  <= mp_pq;
    end
  end

  // Stage 7: calendar day, month and year; January and February belong to the next year.
  logic [8:0]  dom;
  logic [3:0]  mon;
  logic [13:0] yr;

  always_comb begin
    dom = c6_doy - month_base(c6_mp) + 9'd1;
    if (c6_mp < 4'd10) begin
      mon = c6_mp + 4'd3;
    end else begin
      mon = c6_mp - 4'd9;
    end
    yr = 14'(c6_yoe) + 14'(c6_era) * 14'd400 + 14'(mon <= 4'd2);
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[BR_FIRST+6]) begin
      err   <= c6_err;
      year  <= yr;
      month <= mon;
      day   <= dom[4:0];
    end
  end

endmodule

// ===== hw/rtl/em2c_time_of_day.sv =====
// Milliseconds of the day to hour, minute and second over seven stages.
module em2c_time_of_day import em2c_pkg::*; (
  input  logic        clk,
  input  em2c_pipe_t  ctrl,
  input  logic [26:0] msod,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  // Seconds of the day: drop three low bits, then divide by 125 over three stages.
  logic [6:0]  tq_rem [TOD_STAGES];
  logic [16:0] tq_pq  [TOD_STAGES];

  for (genvar s = 0; s < TOD_STAGES; s++) begin : g_sec
    logic [6:0]  src_rem;
    logic [16:0] src_pq;
    logic [6:0]  rem_n;
    logic [16:0] pq_n;
    logic [7:0]  trial;

    if (s == 0) begin : g_src
      assign src_rem = msod[26:20];
      assign src_pq  = msod[19:3];
    end else begin : g_src
      assign src_rem = tq_rem[s-1];
      assign src_pq  = tq_pq[s-1];
    end

    always_comb begin
      rem_n = src_rem;
      pq_n  = src_pq;
      trial = '0;
      for (int j = 0; j < TOD_STEPS_PER_STAGE; j++) begin
        if (s * TOD_STEPS_PER_STAGE + j < TOD_STEPS) begin
          trial = {rem_n, pq_n[16]};
          pq_n  = {pq_n[15:0], trial >= SEC_DIV};
          if (pq_n[0]) begin
            rem_n = 7'(trial - SEC_DIV);
          end else begin
            rem_n = trial[6:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.ld[BR_FIRST+s]) begin
        tq_rem[s] <= rem_n;
        tq_pq[s]  <= pq_n;
      end
    end
  end

  // Hours: seconds of the day over 3600.
  logic [16:0] secs;
  logic [11:0] h_rem;
  logic [4:0]  h_pq;
  logic [12:0] h_trial;
  logic [4:0]  t4_hour;
  logic [11:0] t4_srem;

  assign secs = tq_pq[TOD_STAGES-1];

  always_comb begin
    h_rem   = secs[16:5];
    h_pq    = secs[4:0];
    h_trial = '0;
    for (int j = 0; j < 5; j++) begin
      h_trial = {h_rem, h_pq[4]};
      h_pq    = {h_pq[3:0], h_trial >= SECS_PER_HOUR};
      if (h_pq[0]) begin
        h_rem = 12'(h_trial - SECS_PER_HOUR);
      end else begin
        h_rem = h_trial[11:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[BR_FIRST+3]) begin
      t4_hour <= h_pq;
      t4_srem <= h_rem;
    end
  end

  // Minutes and seconds: seconds of the hour over 60.
  logic [5:0] m_rem;
  logic [5:0] m_pq;
  logic [6:0] m_trial;
  logic [4:0] t5_hour;
  logic [5:0] t5_min;
  logic [5:0] t5_sec;

  always_comb begin
    m_rem   = t4_srem[11:6];
    m_pq    = t4_srem[5:0];
    m_trial = '0;
    for (int j = 0; j < 6; j++) begin
      m_trial = {m_rem, m_pq[5]};
      m_pq    = {m_pq[4:0], m_trial >= SECS_PER_MIN};
      if (m_pq[0]) begin
        m_rem = 6'(m_trial - SECS_PER_MIN);
      end else begin
        m_rem = m_trial[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld[BR_FIRST+4]) begin
      t5_hour <= t4_hour;
      t5_min  <= m_pq;
      t5_sec  <= m_rem;
    end
  end

  // Two delay stages keep this branch level with the date branch.
  logic [4:0] t6_hour;
  logic [5:0] t6_min;
  logic [5:0] t6_sec;

  always_ff @(posedge clk) begin
    if (ctrl.ld[BR_FIRST+5]) begin
      t6_hour <= t5_hour;
      t6_min  <= t5_min;
      t6_sec  <= t5_sec;
    end
    if (ctrl.ld[BR_FIRST+6]) begin
      hour   <= t6_hour;
      minute <= t6_min;
      second <= t6_sec;
    end
  end

endmodule

// ===== hw/rtl/em2c_checker.sv =====
// Port-level checker of the epoch-to-calendar block and its bind to the top level.
`include "epoch_ms_to_local_calendar_assert.svh"

module em2c_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [0:0]  m_tuser
);

  logic        stalled;
  logic        res_ok;
  logic [40:0] res_word;
  logic        date_ok;
  logic        time_ok;

  assign stalled  = m_tvalid && !m_tready;
  assign res_ok   = m_tvalid && !m_tuser[0];
  assign res_word = {m_tuser, m_tdata};
  assign date_ok  = m_tdata[17:14] >= 4'd1 && m_tdata[17:14] <= 4'd12 &&
                    m_tdata[22:18] >= 5'd1;
  assign time_ok  = m_tdata[27:23] <= 5'd23 && m_tdata[33:28] <= 6'd59 &&
                    m_tdata[39:34] <= 6'd59;

  `EM2C_ASSERT_NXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid)
  `EM2C_ASSERT_NXT(a_stall_holds, clk, rst, stalled, m_tvalid && $stable(res_word))
  `EM2C_ASSERT_IMP(a_error_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata == 40'd0)
  `EM2C_ASSERT_IMP(a_date_range, clk, rst, res_ok, date_ok)
  `EM2C_ASSERT_IMP(a_time_range, clk, rst, res_ok, time_ok)

endmodule

bind epoch_ms_to_local_calendar em2c_checker u_em2c_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
